@@ hdl/akdh_pkg.sv @@
// Shared types and constants for the averaged knob direction hysteresis block.
// Holds the field widths, register indexes and the control/status structs.
// No dependencies.
package akdh_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W   = 10;
    localparam int BAND_W     = 8;
    localparam int COUNT_W    = 5;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    // Default depth of the sample history.
    localparam int DEFAULT_HISTORY_DEPTH = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_BAND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT   = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [BAND_W-1:0]  BAND_RESET  = 8'd8;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // write the new sample and prime the read address
        logic rd_en;     // read one history entry and step the address back
        logic div_step;  // one restoring division step
        logic commit;    // apply the hysteresis rule and present the request
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // the result register can take a new request
    } ctrl_status_t;

endpackage

@@ hdl/averaged_knob_direction_hysteresis_top.sv @@
// Top level of the averaged knob direction hysteresis block.
// Depends on akdh_pkg, akdh_ctrl, akdh_datapath (and akdh_ram below it).
//
// Usage:
// Samples enter on sample_valid/sample_stall/knob_sample; a request is taken
// when sample_valid is high and sample_stall low. Each sample gives exactly
// one result request on result_valid/result_stall carrying knob_value,
// value_changed and falling_direction. Configuration writes arrive on
// cfg_valid/cfg_ready with cfg_index (0 band, 1 average count) and cfg_data;
// cfg_ready is always high and writes are meant for idle periods only.
// A sample is worked in order: history reads through the single RAM read port,
// one per averaged entry, then the add of the last read word, then one step of
// the bit-serial divider per bit of the SUM_W = 10 + clog2(depth + 1) bit sum
// (15 at the default depth), then the commit. The next sample is taken only
// after the commit. A stalled result holds the commit, and with it the input
// side stays stalled. Reset clears the history to zeros (via written flags, no
// clearing pass), the pointer, held value, direction and result flags, and sets
// the configuration registers to their reset values.
module averaged_knob_direction_hysteresis_top #(
    parameter int HISTORY_DEPTH = akdh_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [akdh_pkg::SAMPLE_W-1:0]   knob_sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [akdh_pkg::SAMPLE_W-1:0]   knob_value,
    output logic                            value_changed,
    output logic                            falling_direction,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [akdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [akdh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import akdh_pkg::*;

    localparam int NW = $clog2(HISTORY_DEPTH + 1);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic [NW-1:0] eff_count;

    assign cfg_ready = 1'b1;

    akdh_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .eff_count    (eff_count),
        .status       (status),
        .cmd          (cmd)
    );

    akdh_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .knob_sample       (knob_sample),
        .cmd               (cmd),
        .status            (status),
        .eff_count         (eff_count),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .knob_value        (knob_value),
        .value_changed     (value_changed),
        .falling_direction (falling_direction)
    );

    // At most one datapath operation is commanded in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.rd_en, cmd.div_step, cmd.commit}))
        else $error("controller issued overlapping datapath commands");

    // A commit never overwrites a result that is still being held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(result_valid && result_stall))
        else $error("result overwritten while stalled");

    // After a sample is loaded the input side is held off while it is worked.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> sample_stall && !result_valid || sample_stall)
        else $error("input accepted again before the sample was worked");

    // Every commit presents a result request in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid)
        else $error("commit did not present a result");

endmodule

@@ hdl/akdh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the sample history.
module akdh_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/akdh_ctrl.sv @@
// Controller state machine: sequences load, summation, division and commit.
// Depends on akdh_pkg.
module akdh_ctrl #(
    parameter int HISTORY_DEPTH = akdh_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0] eff_count,
    input  akdh_pkg::ctrl_status_t             status,
    output akdh_pkg::ctrl_cmd_t                cmd
);
    import akdh_pkg::*;

    localparam int NW     = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + NW;
    localparam int MAXC   = (HISTORY_DEPTH > SUM_W) ? HISTORY_DEPTH : SUM_W;
    localparam int CNT_W  = $clog2(MAXC);
    localparam int CW     = (CNT_W > NW) ? CNT_W : NW;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SUM      = 3'd1;
    localparam logic [2:0] ST_SUM_TAIL = 3'd2;
    localparam logic [2:0] ST_DIV      = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sum_last;
    logic             div_last;

    // End-of-loop decodes.
    assign sum_last = (CW'(cnt_reg) == (CW'(eff_count) - CW'(1)));
    assign div_last = (CW'(cnt_reg) == CW'(SUM_W - 1));

    assign sample_stall = (state_reg != ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.rd_en = 1'b1;
                if (sum_last)
                begin
                    state_next = ST_SUM_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SUM_TAIL:
            begin
                // The last read word is added in this cycle.
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hdl/akdh_datapath.sv @@
// Datapath: configuration registers, sample history, accumulator, serial
// divider, hysteresis rule and result register. Depends on akdh_pkg, akdh_ram.
module akdh_datapath #(
    parameter int HISTORY_DEPTH = akdh_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [akdh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [akdh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [akdh_pkg::SAMPLE_W-1:0]       knob_sample,
    input  akdh_pkg::ctrl_cmd_t                 cmd,
    output akdh_pkg::ctrl_status_t              status,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]  eff_count,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [akdh_pkg::SAMPLE_W-1:0]       knob_value,
    output logic                                value_changed,
    output logic                                falling_direction
);
    import akdh_pkg::*;

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int NW     = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + NW;
    localparam int CMP_W  = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int HYS_W  = SAMPLE_W + 2;

    logic [BAND_W-1:0]        band_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [ADDR_W-1:0]        wptr_reg, wptr_next;
    logic [ADDR_W-1:0]        raddr_reg;
    logic [HISTORY_DEPTH-1:0] written_reg;
    logic                     rd_pend_reg;
    logic                     rd_written_reg;
    logic [SAMPLE_W-1:0]      rd_data;
    logic [SUM_W-1:0]         acc_reg;
    logic [NW-1:0]            rem_reg;
    logic [NW:0]              rem_shift;
    logic [NW:0]              rem_trial;
    logic                     q_bit;
    logic [SAMPLE_W-1:0]      held_reg;
    logic                     falling_reg;
    logic                     changed_reg;
    logic                     result_valid_reg;

    logic signed [HYS_W-1:0]  avg_s;
    logic signed [HYS_W-1:0]  held_s;
    logic signed [HYS_W-1:0]  band_s;
    logic signed [HYS_W-1:0]  step_s;
    logic signed [HYS_W-1:0]  held_new_s;
    logic                     falling_new;
    logic                     changed_new;

    // Configuration writes; the port never holds off a request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg  <= BAND_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HYSTERESIS_BAND: band_reg  <= cfg_data[BAND_W-1:0];
                CFG_AVERAGE_COUNT:   count_reg <= cfg_data[COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Effective count: zero becomes one, values beyond the depth saturate.
    always_comb
    begin
        if (count_reg == '0)
        begin
            eff_count = NW'(1);
        end
        else if (CMP_W'(count_reg) > CMP_W'(HISTORY_DEPTH))
        begin
            eff_count = NW'(HISTORY_DEPTH);
        end
        else
        begin
            eff_count = NW'(count_reg);
        end
    end

    // Write pointer advances before each sample is stored.
    assign wptr_next = (wptr_reg == ADDR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                : wptr_reg + ADDR_W'(1);

    akdh_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (cmd.load),
        .wr_addr (wptr_next),
        .wr_data (knob_sample),
        .rd_en   (cmd.rd_en),
        .rd_addr (raddr_reg),
        .rd_data (rd_data)
    );

    // Pointer, written flags and the read address walking back from newest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg       <= '0;
            written_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            rd_written_reg <= 1'b0;
            raddr_reg      <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                wptr_reg               <= wptr_next;
                written_reg[wptr_next] <= 1'b1;
                raddr_reg              <= wptr_next;
            end
            else if (cmd.rd_en)
            begin
                rd_written_reg <= written_reg[raddr_reg];
                raddr_reg      <= (raddr_reg == '0) ? ADDR_W'(HISTORY_DEPTH - 1)
                                                    : raddr_reg - ADDR_W'(1);
            end
        end
    end

    // Restoring division step: remainder takes the next dividend bit.
    assign rem_shift = {rem_reg, acc_reg[SUM_W-1]};
    assign rem_trial = rem_shift - (NW+1)'(eff_count);
    assign q_bit     = (rem_shift >= (NW+1)'(eff_count));

    // Accumulator doubles as the dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            if (rd_written_reg)
            begin
                acc_reg <= acc_reg + SUM_W'(rd_data);
            end
        end
        else if (cmd.div_step)
        begin
            acc_reg <= {acc_reg[SUM_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_trial[NW-1:0] : rem_shift[NW-1:0];
        end
    end

    // Hysteresis rule on the average, compared signed.
    always_comb
    begin
        avg_s       = HYS_W'(acc_reg[SAMPLE_W-1:0]);
        held_s      = HYS_W'(held_reg);
        band_s      = HYS_W'(band_reg);
        step_s      = held_s;
        held_new_s  = held_s;
        falling_new = falling_reg;
        changed_new = 1'b0;
        if (!falling_reg)
        begin
            if (avg_s > held_s)
            begin
                step_s      = avg_s;
                changed_new = 1'b1;
            end
            held_new_s = step_s;
            if (avg_s < step_s - band_s)
            begin
                falling_new = 1'b1;
                held_new_s  = avg_s;
                changed_new = 1'b1;
            end
        end
        else
        begin
            if (avg_s < held_s)
            begin
                step_s      = avg_s;
                changed_new = 1'b1;
            end
            held_new_s = step_s;
            if (avg_s > step_s + band_s)
            begin
                falling_new = 1'b0;
                held_new_s  = avg_s;
                changed_new = 1'b1;
            end
        end
    end

    // Held state doubles as the result register; it only moves when free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= '0;
            falling_reg      <= 1'b0;
            changed_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                held_reg         <= held_new_s[SAMPLE_W-1:0];
                falling_reg      <= falling_new;
                changed_reg      <= changed_new;
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free   = !result_valid_reg || !result_stall;
    assign result_valid      = result_valid_reg;
    assign knob_value        = held_reg;
    assign value_changed     = changed_reg;
    assign falling_direction = falling_reg;

endmodule
